// ===== src/gasp_pkg.sv =====
// Shared constants, types and codes for the glyph atlas shelf packer.
package gasp_pkg;

    localparam int MAX_PAGES = 8;
    localparam int PAGE_AW   = (MAX_PAGES > 1) ? $clog2(MAX_PAGES) : 1;
    localparam int CNT_W     = $clog2(MAX_PAGES + 1);

    localparam int DIM_W     = 13;
    localparam int SUM_W     = DIM_W + 1;
    localparam logic [DIM_W-1:0] DIM_LIMIT = 13'd4096;

    localparam int PADDR_W   = 4;

    // register indexes, taken from paddr[3:2]
    localparam logic [1:0] REG_ATLAS_WIDTH  = 2'd0;
    localparam logic [1:0] REG_ATLAS_HEIGHT = 2'd1;
    localparam logic [1:0] REG_PADDING      = 2'd2;

    // result status codes
    localparam logic [1:0] ST_PLACED   = 2'd0;
    localparam logic [1:0] ST_NO_SPACE = 2'd1;
    localparam logic [1:0] ST_TOO_BIG  = 2'd2;
    localparam logic [1:0] ST_CLEARED  = 2'd3;

    localparam logic CMD_PLACE = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic [DIM_W-1:0] x;
        logic [DIM_W-1:0] y;
        logic [DIM_W-1:0] h;
    } shelf_t;

    typedef struct packed {
        logic             open_ok;
        logic             new_ok;
        logic [DIM_W-1:0] tall;
        logic [DIM_W-1:0] x_next;
        logic [DIM_W-1:0] y_next;
    } fit_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [2:0]  page;
        logic [11:0] pos_x;
        logic [11:0] pos_y;
        logic        opened;
    } result_t;

    typedef struct packed {
        logic [DIM_W-1:0] aw;
        logic [DIM_W-1:0] ah;
        logic [3:0]       pad;
    } cfg_t;

endpackage

// ===== src/gasp_cfg.sv =====
// APB register block: page size and padding, page size clamped for the datapath.
module gasp_cfg
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gasp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready,
    output gasp_pkg::cfg_t               cfg
);
    import gasp_pkg::*;

    logic [DIM_W-1:0] atlas_width_reg;
    logic [DIM_W-1:0] atlas_height_reg;
    logic [3:0]       padding_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            atlas_width_reg  <= 13'd1024;
            atlas_height_reg <= 13'd1024;
            padding_reg      <= 4'd1;
        end
        else if (wr_en)
        begin
            unique case (paddr[3:2])
                REG_ATLAS_WIDTH:  atlas_width_reg  <= pwdata[DIM_W-1:0];
                REG_ATLAS_HEIGHT: atlas_height_reg <= pwdata[DIM_W-1:0];
                REG_PADDING:      padding_reg      <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_ATLAS_WIDTH:  prdata = {19'd0, atlas_width_reg};
            REG_ATLAS_HEIGHT: prdata = {19'd0, atlas_height_reg};
            REG_PADDING:      prdata = {28'd0, padding_reg};
            default:          prdata = 32'd0;
        endcase
    end

    // sizes above 4096 behave as 4096
    assign cfg.aw  = (atlas_width_reg  > DIM_LIMIT) ? DIM_LIMIT : atlas_width_reg;
    assign cfg.ah  = (atlas_height_reg > DIM_LIMIT) ? DIM_LIMIT : atlas_height_reg;
    assign cfg.pad = padding_reg;

endmodule

// ===== src/gasp_shelf_mem.sv =====
// Per-page shelf store: x cursor, shelf top and shelf height, registered read.
module gasp_shelf_mem
(
    input  logic                         clk,
    input  logic                         we,
    input  logic [gasp_pkg::PAGE_AW-1:0] waddr,
    input  gasp_pkg::shelf_t             wdata,
    input  logic [gasp_pkg::PAGE_AW-1:0] raddr,
    output gasp_pkg::shelf_t             rdata
);
    import gasp_pkg::*;

    shelf_t mem [MAX_PAGES];
    shelf_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/gasp_fit.sv =====
// Shared fit unit: tests one page's open shelf and a new shelf below it.
module gasp_fit
(
    input  gasp_pkg::shelf_t                shelf,
    input  logic [gasp_pkg::DIM_W-1:0]      pw,
    input  logic [gasp_pkg::DIM_W-1:0]      ph,
    input  logic [gasp_pkg::DIM_W-1:0]      aw,
    input  logic [gasp_pkg::DIM_W-1:0]      ah,
    output gasp_pkg::fit_t                  fit
);
    import gasp_pkg::*;

    logic [DIM_W-1:0] tall;
    logic [SUM_W-1:0] x_sum;
    logic [SUM_W-1:0] top_sum;
    logic [SUM_W-1:0] next_y;
    logic [SUM_W-1:0] new_sum;

    assign tall    = (shelf.h > ph) ? shelf.h : ph;
    assign x_sum   = {1'b0, shelf.x} + {1'b0, pw};
    assign top_sum = {1'b0, shelf.y} + {1'b0, tall};
    assign next_y  = {1'b0, shelf.y} + {1'b0, shelf.h};
    assign new_sum = next_y + {1'b0, ph};

    assign fit.open_ok = (x_sum <= {1'b0, aw}) && (top_sum <= {1'b0, ah});
    assign fit.new_ok  = (new_sum <= {1'b0, ah});
    assign fit.tall    = tall;
    assign fit.x_next  = x_sum[DIM_W-1:0];
    assign fit.y_next  = next_y[DIM_W-1:0];

endmodule

// ===== src/glyph_atlas_shelf_packer.sv =====
// Top level of the glyph atlas shelf packer: stream ports, sequencer, result register.
// One request at a time. A clear or a rejected rectangle goes from CHECK
// straight to EMIT; a placement is tried on pages in order from 0 in SCAN, and
// opening a new page or reporting that all pages are full follows a scan of
// every page in use (at most MAX_PAGES). The single fit unit tests one page a
// cycle against a registered read of the shelf store. A finished result waits
// in the output register while the next request is taken. No clearing pass
// after reset.
module glyph_atlas_shelf_packer
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [23:0]                  s_tdata,  // rect_width[11:0], rect_height[23:12]
    input  logic                         s_tuser,  // command
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,  // page_index[2:0], pos_x[14:3],
                                                   // pos_y[26:15], opened_page[27]
    output logic [1:0]                   m_tuser,  // status
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [gasp_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import gasp_pkg::*;

    typedef enum logic [1:0] {IDLE, CHECK, SCAN, EMIT} state_t;

    state_t           state_reg;
    logic             cmd_reg;
    logic [DIM_W-1:0] pw_reg;
    logic [DIM_W-1:0] ph_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [CNT_W-1:0] pages_reg;
    result_t          res_reg;
    logic             m_tvalid_reg;
    result_t          m_res_reg;

    cfg_t             cfg;
    shelf_t           rdata;
    shelf_t           wdata;
    fit_t             fit;
    logic             mem_we;
    logic [PAGE_AW-1:0] waddr;
    logic [PAGE_AW-1:0] raddr;
    logic [CNT_W-1:0] cnt_inc;
    logic             in_range;
    logic             full;
    logic             too_big;
    logic             out_free;

    gasp_cfg u_cfg
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    gasp_shelf_mem u_mem
    (
        .clk   (clk),
        .we    (mem_we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rdata)
    );

    gasp_fit u_fit
    (
        .shelf (rdata),
        .pw    (pw_reg),
        .ph    (ph_reg),
        .aw    (cfg.aw),
        .ah    (cfg.ah),
        .fit   (fit)
    );

    assign s_tready = (state_reg == IDLE);
    assign out_free = !m_tvalid_reg || m_tready;
    assign in_range = (cnt_reg < pages_reg);
    assign full     = (pages_reg == CNT_W'(MAX_PAGES));
    assign too_big  = (pw_reg == '0) || (ph_reg == '0) ||
                      (pw_reg > cfg.aw) || (ph_reg > cfg.ah);
    assign cnt_inc  = cnt_reg + 1'b1;

    // read one page ahead: page 0 while checking, the next page while scanning
    assign raddr = (state_reg == SCAN) ? cnt_inc[PAGE_AW-1:0] : '0;

    always_comb
    begin
        mem_we = 1'b0;
        waddr  = cnt_reg[PAGE_AW-1:0];
        wdata  = rdata;
        if (state_reg == SCAN)
        begin
            if (in_range)
            begin
                if (fit.open_ok)
                begin
                    mem_we  = 1'b1;
                    wdata.x = fit.x_next;
                    wdata.h = fit.tall;
                end
                else if (fit.new_ok)
                begin
                    mem_we  = 1'b1;
                    wdata.x = pw_reg;
                    wdata.y = fit.y_next;
                    wdata.h = ph_reg;
                end
            end
            else if (!full)
            begin
                mem_we  = 1'b1;
                waddr   = pages_reg[PAGE_AW-1:0];
                wdata.x = pw_reg;
                wdata.y = '0;
                wdata.h = ph_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= IDLE;
            cmd_reg      <= 1'b0;
            pw_reg       <= '0;
            ph_reg       <= '0;
            cnt_reg      <= '0;
            pages_reg    <= '0;
            res_reg      <= '0;
            m_tvalid_reg <= 1'b0;
            m_res_reg    <= '0;
        end
        else
        begin
            if ((state_reg == EMIT) && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tvalid_reg && m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            unique case (state_reg)
                IDLE:
                begin
                    if (s_tvalid)
                    begin
                        cmd_reg   <= s_tuser;
                        pw_reg    <= {1'b0, s_tdata[11:0]} + {9'd0, cfg.pad};
                        ph_reg    <= {1'b0, s_tdata[23:12]} + {9'd0, cfg.pad};
                        state_reg <= CHECK;
                    end
                end
                CHECK:
                begin
                    cnt_reg <= '0;
                    if (cmd_reg == CMD_CLEAR)
                    begin
                        pages_reg <= '0;
                        res_reg   <= '{status: ST_CLEARED, default: '0};
                        state_reg <= EMIT;
                    end
                    else if (too_big)
                    begin
                        res_reg   <= '{status: ST_TOO_BIG, default: '0};
                        state_reg <= EMIT;
                    end
                    else
                    begin
                        res_reg   <= '0;
                        state_reg <= SCAN;
                    end
                end
                SCAN:
                begin
                    if (in_range)
                    begin
                        if (fit.open_ok || fit.new_ok)
                        begin
                            res_reg <= '{status: ST_PLACED,
                                         page:   3'(cnt_reg),
                                         pos_x:  fit.open_ok ? rdata.x[11:0] : 12'd0,
                                         pos_y:  fit.open_ok ? rdata.y[11:0]
                                                             : fit.y_next[11:0],
                                         opened: 1'b0};
                            state_reg <= EMIT;
                        end
                        else
                        begin
                            cnt_reg <= cnt_inc;
                        end
                    end
                    else if (full)
                    begin
                        res_reg   <= '{status: ST_NO_SPACE, default: '0};
                        state_reg <= EMIT;
                    end
                    else
                    begin
                        res_reg   <= '{status: ST_PLACED,
                                       page:   3'(pages_reg),
                                       pos_x:  12'd0,
                                       pos_y:  12'd0,
                                       opened: 1'b1};
                        pages_reg <= pages_reg + 1'b1;
                        state_reg <= EMIT;
                    end
                end
                EMIT:
                begin
                    if (out_free)
                    begin
                        m_res_reg <= res_reg;
                        state_reg <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = m_res_reg.status;
    assign m_tdata  = {4'd0, m_res_reg.opened, m_res_reg.pos_y,
                       m_res_reg.pos_x, m_res_reg.page};

    a_pages_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pages_reg <= CNT_W'(MAX_PAGES))
        else $error("page count above limit");

    a_reject_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != ST_PLACED) |-> (m_tdata == 32'd0))
        else $error("non-placement carries coordinates");

    a_open_origin: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[27] |->
            (m_tuser == ST_PLACED) && (m_tdata[26:3] == 24'd0))
        else $error("new page placement not at origin");

    a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request taken while busy");

endmodule
